// File: src/svm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svm_pkg
// Shared constants, types and the saturation helper function of the linear SVM trainer.
// ----------------------------------------------------------------------------
package svm_pkg;

  localparam int MaxFeatures = 64;
  localparam int MaxClasses  = 16;
  localparam int FeatAw      = $clog2(MaxFeatures);
  localparam int ClassAw     = $clog2(MaxClasses);
  localparam int WAddrW      = FeatAw + ClassAw;
  localparam int WDepth      = MaxFeatures * MaxClasses;

  // Operation codes of an input transaction.
  localparam logic [1:0] OpTrain    = 2'd0;
  localparam logic [1:0] OpClassify = 2'd1;
  localparam logic [1:0] OpClear    = 2'd2;

  // Configuration register indexes.
  localparam logic [2:0] CfgLearnRate = 3'd0;
  localparam logic [2:0] CfgRegStr    = 3'd1;
  localparam logic [2:0] CfgHardMrg   = 3'd2;
  localparam logic [2:0] CfgFeatCnt   = 3'd3;
  localparam logic [2:0] CfgClassCnt  = 3'd4;

  // C = 1000.0 in Q16.16 for hard-margin mode.
  localparam logic [31:0] HardC = 32'd65536000;
  // 1.0 in Q16.16.
  localparam logic signed [32:0] OneQ16 = 33'sd65536;

  typedef struct packed {
    logic [15:0] lr;
    logic [31:0] c;
    logic [6:0]  nf;
    logic [4:0]  nc;
    logic        binary;
  } cfg_t;

  typedef struct packed {
    logic               wipe_we;
    logic [WAddrW-1:0]  wipe_addr;
    logic               bias_clr;
    logic               buf_we;
    logic [FeatAw-1:0]  buf_addr;
    logic [15:0]        buf_data;
    logic               rd_en;
    logic [FeatAw-1:0]  feat;
    logic [ClassAw-1:0] col;
    logic               x_zero;
    logic               acc_init;
    logic               mac_en;
    logic               acc_en;
    logic               score_en;
    logic               pos;
    logic               train;
    logic               cyx_en;
    logic               upd_en;
    logic               w_we;
    logic               lc_en;
    logic               bias_we;
    logic               emit_en;
    logic [ClassAw-1:0] emit_idx;
    logic               emit_last;
  } cmd_t;

  typedef struct packed {
    logic decay;
    logic out_free;
  } sts_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (v < -64'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

// File: src/svm_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svm_dp
// Datapath: sample buffer, weight memory, biases, MAC, update arithmetic
// and the output register.
// ----------------------------------------------------------------------------
module svm_dp import svm_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  cfg_t                cfg_i,
  input  cmd_t                cmd_i,
  output sts_t                sts_o,
  input  logic                out_ready_i,
  output logic                out_valid_o,
  output logic [ClassAw-1:0]  class_index_o,
  output logic signed [31:0]  score_o,
  output logic [ClassAw-1:0]  predicted_class_o,
  output logic                last_res_o
);

  logic signed [15:0] sbuf_mem [MaxFeatures];
  logic signed [15:0] sbuf_rd_q;
  logic               x_zero_q;
  logic signed [31:0] wmem [WDepth];
  logic signed [31:0] w_rd_q;
  logic [WAddrW-1:0]  waddr;
  logic [WAddrW-1:0]  wr_addr;
  logic signed [31:0] wr_data;
  logic               wr_en;
  logic signed [31:0] bias_q [MaxClasses];
  logic signed [31:0] bias_sel;
  logic signed [15:0] x_val;
  logic signed [47:0] mac_q;
  logic signed [63:0] acc_q;
  logic signed [31:0] score_sat;
  logic signed [32:0] margin;
  logic               decay_q;
  logic signed [31:0] scores_q [MaxClasses];
  logic [ClassAw-1:0] best_idx_q;
  logic signed [31:0] best_score_q;
  logic signed [16:0] xs;
  logic signed [49:0] cyx_q;
  logic signed [43:0] t_val;
  logic signed [60:0] upd_q;
  logic signed [63:0] w_new_wide;
  logic signed [31:0] w_new;
  logic [47:0]        lc_q;
  logic signed [63:0] lc_s;
  logic signed [63:0] lc_sh;
  logic signed [31:0] bias_new;
  logic               out_valid_q;
  logic [ClassAw-1:0] class_q;
  logic signed [31:0] score_out_q;
  logic [ClassAw-1:0] pred_q;
  logic               last_q;

  assign waddr = {cmd_i.feat, cmd_i.col};

  // Sample buffer.
  always_ff @(posedge clk_i) begin
    if (cmd_i.buf_we) begin
      sbuf_mem[cmd_i.buf_addr] <= cmd_i.buf_data;
    end
    if (cmd_i.rd_en) begin
      sbuf_rd_q <= sbuf_mem[cmd_i.feat];
      x_zero_q  <= cmd_i.x_zero;
    end
  end

  assign x_val = x_zero_q ? 16'sd0 : sbuf_rd_q;

  // Weight memory: the clearing sweep and the update share one write port.
  assign wr_en   = cmd_i.wipe_we | cmd_i.w_we;
  assign wr_addr = cmd_i.wipe_we ? cmd_i.wipe_addr : waddr;
  assign wr_data = cmd_i.wipe_we ? 32'sd0 : w_new;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      wmem[wr_addr] <= wr_data;
    end
    if (cmd_i.rd_en) begin
      w_rd_q <= wmem[waddr];
    end
  end

  assign bias_sel = bias_q[cmd_i.col];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MaxClasses; i++) begin
        bias_q[i] <= '0;
      end
    end else if (cmd_i.bias_clr) begin
      for (int i = 0; i < MaxClasses; i++) begin
        bias_q[i] <= '0;
      end
    end else if (cmd_i.bias_we) begin
      bias_q[cmd_i.col] <= bias_new;
    end
  end

  // Score accumulation in Q.24.
  assign score_sat = sat32(acc_q >>> 8);
  assign margin    = cmd_i.pos ? 33'(score_sat) : -33'(score_sat);

  always_ff @(posedge clk_i) begin
    if (cmd_i.mac_en) begin
      mac_q <= w_rd_q * x_val;
    end
    if (cmd_i.acc_init) begin
      acc_q <= {{24{bias_sel[31]}}, bias_sel, 8'b0};
    end else if (cmd_i.acc_en) begin
      acc_q <= acc_q + 64'(mac_q);
    end
    if (cmd_i.score_en) begin
      decay_q <= (margin >= OneQ16);
      if (!cmd_i.train) begin
        scores_q[cmd_i.col] <= score_sat;
        if (cmd_i.col == '0 || score_sat > best_score_q) begin
          best_idx_q   <= cmd_i.col;
          best_score_q <= score_sat;
        end
      end
    end
  end

  // Weight update: w - floor(lr * (w - floor(C*y*x / 256)) / 65536).
  // The decay case is the same path with C*y*x forced to zero.
  assign xs    = cmd_i.pos ? 17'(x_val) : -17'(x_val);
  assign t_val = 44'(w_rd_q) - 44'(cyx_q >>> 8);
  assign w_new_wide = 64'(w_rd_q) - 64'(upd_q >>> 16);
  assign w_new = sat32(w_new_wide);

  always_ff @(posedge clk_i) begin
    if (cmd_i.cyx_en) begin
      cyx_q <= decay_q ? 50'sd0 : $signed({1'b0, cfg_i.c}) * xs;
    end
    if (cmd_i.upd_en) begin
      upd_q <= $signed({1'b0, cfg_i.lr}) * t_val;
    end
    if (cmd_i.lc_en) begin
      lc_q <= cfg_i.lr * cfg_i.c;
    end
  end

  // Bias step: bias + floor(+-lr*C / 65536).
  assign lc_s     = $signed({16'b0, lc_q});
  assign lc_sh    = cmd_i.pos ? (lc_s >>> 16) : ((-lc_s) >>> 16);
  assign bias_new = sat32(64'(bias_sel) + lc_sh);

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit_en) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_en) begin
      class_q     <= cfg_i.binary ? ClassAw'(1) : cmd_i.emit_idx;
      score_out_q <= scores_q[cmd_i.emit_idx];
      pred_q      <= cfg_i.binary ? ClassAw'(scores_q[cmd_i.emit_idx] > 32'sd0)
                                  : best_idx_q;
      last_q      <= cmd_i.emit_last;
    end
  end

  assign sts_o.decay    = decay_q;
  assign sts_o.out_free = !out_valid_q || out_ready_i;

  assign out_valid_o       = out_valid_q;
  assign class_index_o     = class_q;
  assign score_o           = score_out_q;
  assign predicted_class_o = pred_q;
  assign last_res_o        = last_q;

endmodule

// File: src/svm_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svm_ctrl
// Controller: sample intake, score and update passes, clearing sweep and
// result emission.
// ----------------------------------------------------------------------------
module svm_ctrl import svm_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cfg_t        cfg_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  op_i,
  input  logic [15:0] feature_value_i,
  input  logic [3:0]  label_index_i,
  input  logic        last_i,
  input  sts_t        sts_i,
  output cmd_t        cmd_o
);

  localparam logic [3:0] StWipe  = 4'd0;
  localparam logic [3:0] StIdle  = 4'd1;
  localparam logic [3:0] StLoad  = 4'd2;
  localparam logic [3:0] StSRd   = 4'd3;
  localparam logic [3:0] StSMul  = 4'd4;
  localparam logic [3:0] StSAcc  = 4'd5;
  localparam logic [3:0] StScore = 4'd6;
  localparam logic [3:0] StURd   = 4'd7;
  localparam logic [3:0] StUMul1 = 4'd8;
  localparam logic [3:0] StUMul2 = 4'd9;
  localparam logic [3:0] StUWr   = 4'd10;
  localparam logic [3:0] StBMul  = 4'd11;
  localparam logic [3:0] StBWr   = 4'd12;
  localparam logic [3:0] StNext  = 4'd13;
  localparam logic [3:0] StEmit  = 4'd14;

  logic [3:0]         state_q, state_d;
  logic [ClassAw-1:0] col_q, col_d;
  logic [FeatAw-1:0]  feat_q, feat_d;
  logic [6:0]         cnt_q, cnt_d;
  logic [6:0]         n_q, n_d;
  logic [3:0]         label_q, label_d;
  logic               train_q, train_d;
  logic [WAddrW-1:0]  wipe_q, wipe_d;
  logic [ClassAw-1:0] emit_q, emit_d;
  logic               accept;
  logic               room;
  logic [6:0]         nf_last;
  logic [4:0]         nc_last;
  logic [ClassAw-1:0] cols_last;
  logic               feat_end;

  assign in_ready_o = (state_q == StIdle);
  assign accept     = in_valid_i && in_ready_o;
  assign room       = (cnt_q < 7'(MaxFeatures));
  assign nf_last    = cfg_i.nf - 7'd1;
  assign nc_last    = cfg_i.nc - 5'd1;
  assign cols_last  = cfg_i.binary ? '0 : nc_last[ClassAw-1:0];
  assign feat_end   = (feat_q == nf_last[FeatAw-1:0]);

  always_comb begin
    state_d = state_q;
    col_d   = col_q;
    feat_d  = feat_q;
    cnt_d   = cnt_q;
    n_d     = n_q;
    label_d = label_q;
    train_d = train_q;
    wipe_d  = wipe_q;
    emit_d  = emit_q;
    cmd_o   = '0;

    cmd_o.feat      = feat_q;
    cmd_o.col       = col_q;
    cmd_o.x_zero    = ({1'b0, feat_q} >= n_q);
    cmd_o.pos       = cfg_i.binary ? (label_q == 4'd1) : (label_q == 4'(col_q));
    cmd_o.train     = train_q;
    cmd_o.wipe_addr = wipe_q;
    cmd_o.buf_addr  = cnt_q[FeatAw-1:0];
    cmd_o.buf_data  = feature_value_i;
    cmd_o.emit_idx  = emit_q;
    cmd_o.emit_last = (emit_q == cols_last);

    unique case (state_q)
      StWipe: begin
        cmd_o.wipe_we = 1'b1;
        wipe_d = wipe_q + 1'b1;
        if (wipe_q == '1) begin
          state_d = StIdle;
        end
      end
      StIdle: begin
        if (accept) begin
          unique case (op_i) inside
            OpClear: begin
              cmd_o.bias_clr = 1'b1;
              cnt_d   = '0;
              wipe_d  = '0;
              state_d = StWipe;
            end
            OpTrain, OpClassify: begin
              cmd_o.buf_we = room;
              if (last_i) begin
                n_d     = room ? cnt_q + 7'd1 : cnt_q;
                cnt_d   = '0;
                label_d = label_index_i;
                train_d = (op_i == OpTrain);
                col_d   = '0;
                state_d = StLoad;
              end else if (room) begin
                cnt_d = cnt_q + 7'd1;
              end
            end
            default: begin
            end
          endcase
        end
      end
      StLoad: begin
        cmd_o.acc_init = 1'b1;
        feat_d  = '0;
        state_d = StSRd;
      end
      StSRd: begin
        cmd_o.rd_en = 1'b1;
        state_d = StSMul;
      end
      StSMul: begin
        cmd_o.mac_en = 1'b1;
        state_d = StSAcc;
      end
      StSAcc: begin
        cmd_o.acc_en = 1'b1;
        if (feat_end) begin
          state_d = StScore;
        end else begin
          feat_d  = feat_q + 1'b1;
          state_d = StSRd;
        end
      end
      StScore: begin
        cmd_o.score_en = 1'b1;
        feat_d  = '0;
        state_d = train_q ? StURd : StNext;
      end
      StURd: begin
        cmd_o.rd_en = 1'b1;
        state_d = StUMul1;
      end
      StUMul1: begin
        cmd_o.cyx_en = 1'b1;
        state_d = StUMul2;
      end
      StUMul2: begin
        cmd_o.upd_en = 1'b1;
        state_d = StUWr;
      end
      StUWr: begin
        cmd_o.w_we = 1'b1;
        if (feat_end) begin
          state_d = sts_i.decay ? StNext : StBMul;
        end else begin
          feat_d  = feat_q + 1'b1;
          state_d = StURd;
        end
      end
      StBMul: begin
        cmd_o.lc_en = 1'b1;
        state_d = StBWr;
      end
      StBWr: begin
        cmd_o.bias_we = 1'b1;
        state_d = StNext;
      end
      StNext: begin
        if (col_q == cols_last) begin
          emit_d  = '0;
          state_d = train_q ? StIdle : StEmit;
        end else begin
          col_d   = col_q + 1'b1;
          state_d = StLoad;
        end
      end
      StEmit: begin
        if (sts_i.out_free) begin
          cmd_o.emit_en = 1'b1;
          if (emit_q == cols_last) begin
            state_d = StIdle;
          end else begin
            emit_d = emit_q + 1'b1;
          end
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StWipe;
      col_q   <= '0;
      feat_q  <= '0;
      cnt_q   <= '0;
      n_q     <= '0;
      label_q <= '0;
      train_q <= 1'b0;
      wipe_q  <= '0;
      emit_q  <= '0;
    end else begin
      state_q <= state_d;
      col_q   <= col_d;
      feat_q  <= feat_d;
      cnt_q   <= cnt_d;
      n_q     <= n_d;
      label_q <= label_d;
      train_q <= train_d;
      wipe_q  <= wipe_d;
      emit_q  <= emit_d;
    end
  end

endmodule

// File: src/linear_svm_sgd_trainer_unit.sv
`timescale 1ns / 1ps
// Sequence: a non-closing element is only buffered; a closing element, per weight
// column, scores with a read, multiply and accumulate step per feature and,
// when training, updates each weight with a read, two multiplies and a write,
// plus the bias step when the margin is missed; a classify then emits results.
// Throughput: one transaction per cycle while a sample is being buffered.
// Reset: control state clears at once, then a sweep zeroes the weight
// memory before the first input transaction is taken; a clear operation repeats it.
// ----------------------------------------------------------------------------
// linear_svm_sgd_trainer_unit
// Linear SVM trained by stochastic gradient descent on the hinge loss.
// ----------------------------------------------------------------------------
module linear_svm_sgd_trainer_unit import svm_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  // Input channel.
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         op_i,
  input  logic signed [15:0] feature_value_i,
  input  logic [3:0]         label_index_i,
  input  logic               last_i,
  // Result channel.
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [3:0]         class_index_o,
  output logic signed [31:0] score_o,
  output logic [3:0]         predicted_class_o,
  output logic               last_res_o,
  // Configuration write port.
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_addr_i,
  input  logic [31:0]        cfg_wdata_i
);

  // Configuration registers, held at their reset values until written.
  logic [15:0] lr_q;
  logic [31:0] reg_str_q;
  logic        hard_q;
  logic [6:0]  feat_cnt_q;
  logic [4:0]  class_cnt_q;
  cfg_t        cfg;
  cmd_t        cmd;
  sts_t        sts;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lr_q        <= 16'd655;
      reg_str_q   <= 32'd65536;
      hard_q      <= 1'b0;
      feat_cnt_q  <= 7'd64;
      class_cnt_q <= 5'd2;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        CfgLearnRate: lr_q        <= cfg_wdata_i[15:0];
        CfgRegStr:    reg_str_q   <= cfg_wdata_i;
        CfgHardMrg:   hard_q      <= cfg_wdata_i[0];
        CfgFeatCnt:   feat_cnt_q  <= cfg_wdata_i[6:0];
        CfgClassCnt:  class_cnt_q <= cfg_wdata_i[4:0];
        default: begin
        end
      endcase
    end
  end

  // The feature and class counts are clamped to the ranges the storage
  // supports. Two classes use a single weight column.
  always_comb begin
    cfg.lr = lr_q;
    cfg.c  = hard_q ? HardC : reg_str_q;
    if (feat_cnt_q == 7'd0) begin
      cfg.nf = 7'd1;
    end else if (feat_cnt_q > 7'(MaxFeatures)) begin
      cfg.nf = 7'(MaxFeatures);
    end else begin
      cfg.nf = feat_cnt_q;
    end
    if (class_cnt_q < 5'd2) begin
      cfg.nc = 5'd2;
    end else if (class_cnt_q > 5'(MaxClasses)) begin
      cfg.nc = 5'(MaxClasses);
    end else begin
      cfg.nc = class_cnt_q;
    end
    cfg.binary = (cfg.nc == 5'd2);
  end

  // The controller sequences every pass; the datapath holds the sample, weight
  // and bias storage and the arithmetic, and the output register lets a new
  // sample be buffered while a result transaction is still waiting.
  svm_ctrl u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .op_i            (op_i),
    .feature_value_i (feature_value_i),
    .label_index_i   (label_index_i),
    .last_i          (last_i),
    .sts_i           (sts),
    .cmd_o           (cmd)
  );

  svm_dp u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_i             (cfg),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .out_ready_i       (out_ready_i),
    .out_valid_o       (out_valid_o),
    .class_index_o     (class_index_o),
    .score_o           (score_o),
    .predicted_class_o (predicted_class_o),
    .last_res_o        (last_res_o)
  );

endmodule

// File: src/svm_chk.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svm_chk
// Port-level checks of the linear SVM trainer, bound to the top level.
// ----------------------------------------------------------------------------
module svm_chk import svm_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic [1:0]  op_i,
  input logic        last_i,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [31:0] score_o
);

  // While reset is held nothing is accepted and no result is shown.
  a_reset_quiet: assert property (@(posedge clk_i)
    !rst_ni |-> !in_ready_o && !out_valid_o)
    else $error("ports active during reset");

  // A clear transaction starts the sweep, so input is refused next cycle.
  a_clear_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && op_i == OpClear |=> !in_ready_o)
    else $error("input taken during clearing sweep");

  // A closing element starts the compute passes.
  a_close_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && last_i && (op_i == OpTrain || op_i == OpClassify)
    |=> !in_ready_o)
    else $error("input taken while a sample is computed");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result withdrawn before transaction");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(score_o))
    else $error("stalled score changed");

endmodule

bind linear_svm_sgd_trainer_unit svm_chk u_svm_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .op_i        (op_i),
  .last_i      (last_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .score_o     (score_o)
);
